// ----- rtl/cosq_pkg.sv -----
// Shared types and codes for the channel-optimised scalar quantiser block.
// No dependencies; imported by the top level and its checker.
package cosq_pkg;

  localparam int OPW = 3;

  typedef enum logic [OPW-1:0] {
    OP_LOAD_CW = 3'd0,
    OP_LOAD_P  = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_ENCODE  = 3'd3,
    OP_UPDATE  = 3'd4
  } cosq_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E_SQ,
    ST_E_MP,
    ST_E_AC,
    ST_E_FN,
    ST_U_MS,
    ST_U_MN,
    ST_U_AN,
    ST_U_CK,
    ST_U_DV,
    ST_U_RD,
    ST_U_EM
  } cosq_state_t;

  localparam logic [16:0] PROB_ONE = 17'd65536;

endpackage

// ----- rtl/cosq_encode_and_centroid_update.sv -----
// Channel-optimised scalar quantiser: encoder and centroid updater.
// Encode: per pair of the L levels in use, square, weight and accumulate on one shared multiplier.
// Update: per codeword an NW-step restoring divider; L results.
// Loads, clear and unknown opcodes finish in the idle state. Not ready while an item is at work.
// Synchronous active-low reset clears control and the accumulator valid bits;
// codebook and transition memories are undefined until written.
module cosq_encode_and_centroid_update
  import cosq_pkg::*;
#(
  parameter int MAX_LEVELS  = 64,
  parameter int MAX_SAMPLES = 1048576
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [5:0]         in_row_index,
  input  logic [5:0]         in_col_index,
  input  logic signed [15:0] in_sample,
  input  logic [16:0]        in_probability,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_cell_index,
  output logic [39:0]        out_cost,
  output logic signed [15:0] out_codeword,
  output logic               out_empty_cell,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_data
);

  localparam int LW   = $clog2(MAX_LEVELS);
  localparam int TAW  = $clog2(MAX_LEVELS * MAX_LEVELS);
  localparam int SW   = $clog2(MAX_SAMPLES) + 16;
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int MA   = (SW >= 33) ? SW : 33;
  localparam int PW   = MA + 18;
  localparam int AW   = 49 + LW;
  localparam int NW   = SW + 17 + LW;
  localparam int DW   = CW + 17 + LW;
  localparam int DCW  = $clog2(NW);

  cosq_state_t state_r, state_nxt;
  logic [2:0]  log2_r;

  logic signed [15:0] x_r, x_nxt;
  logic [LW-1:0] row_r, row_nxt, col_r, col_nxt, best_r, best_nxt;
  logic [AW-1:0] s_r, s_nxt, bcost_r, bcost_nxt;
  logic signed [PW-1:0] prod_r;
  logic signed [MA-1:0] mul_a;
  logic signed [17:0]   mul_b;
  logic signed [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] den_r, den_nxt, rem_r, rem_nxt;
  logic [NW-1:0] dq_r, dq_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic empty_r, empty_nxt;
  logic signed [15:0] cw_r, cw_nxt;

  logic signed [15:0] cb_mem [MAX_LEVELS];
  logic [16:0]        tp_mem [MAX_LEVELS * MAX_LEVELS];
  logic signed [SW-1:0] sum_mem [MAX_LEVELS];
  logic [CW-1:0]      cnt_mem [MAX_LEVELS];
  logic               vld_r [MAX_LEVELS];

  logic signed [15:0] cb_rd_r;
  logic [16:0]        tp_rd_r;
  logic signed [SW-1:0] sum_rd_r;
  logic [CW-1:0]      cnt_rd_r;
  logic               avld_rd_r;
  logic signed [SW-1:0] sum_eff;
  logic [CW-1:0]      cnt_eff;

  logic [LW-1:0]  cb_raddr, acc_raddr, cb_waddr;
  logic [TAW-1:0] tp_raddr, tp_waddr;
  logic           cb_we, tp_we, acc_we, clr;
  logic signed [15:0] cb_wdata;
  logic [16:0]    tp_wdata;

  logic out_valid_r, out_valid_nxt, out_load, out_free;
  logic [5:0]  oidx_r, oidx_nxt;
  logic [39:0] ocost_r, ocost_nxt;
  logic signed [15:0] ocw_r, ocw_nxt;
  logic oempty_r, oempty_nxt, olast_r, olast_nxt;

  logic [8:0]    lvl_full, lvl_use;
  logic [LW-1:0] last_idx;
  logic          in_xfer, row_ok, col_ok;

  logic signed [16:0] d;
  logic [15:0]   ad;
  logic [AW-1:0] esum, csh;
  logic          better;
  logic [DW:0]   rem_sh;
  logic          ge, rnd;
  logic [NW:0]   qr;
  logic [16:0]   q17;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign lvl_full = 9'd1 << log2_r;
  assign lvl_use  = (lvl_full > 9'(MAX_LEVELS)) ? 9'(MAX_LEVELS) : lvl_full;
  assign last_idx = LW'(lvl_use - 9'd1);

  assign row_ok = (32'(in_row_index) < MAX_LEVELS);
  assign col_ok = (32'(in_col_index) < MAX_LEVELS);

  assign sum_eff = avld_rd_r ? sum_rd_r : '0;
  assign cnt_eff = avld_rd_r ? cnt_rd_r : '0;

  assign out_valid      = out_valid_r;
  assign out_cell_index = oidx_r;
  assign out_cost       = ocost_r;
  assign out_codeword   = ocw_r;
  assign out_empty_cell = oempty_r;
  assign out_last       = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      log2_r      <= 3'd4;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        log2_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    best_r   <= best_nxt;
    s_r      <= s_nxt;
    bcost_r  <= bcost_nxt;
    prod_r   <= mul_a * mul_b;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    dq_r     <= dq_nxt;
    dcnt_r   <= dcnt_nxt;
    empty_r  <= empty_nxt;
    cw_r     <= cw_nxt;
    oidx_r   <= oidx_nxt;
    ocost_r  <= ocost_nxt;
    ocw_r    <= ocw_nxt;
    oempty_r <= oempty_nxt;
    olast_r  <= olast_nxt;
  end

  always_comb begin
    cb_raddr  = col_nxt;
    tp_raddr  = TAW'(32'(row_nxt) * MAX_LEVELS + 32'(col_nxt));
    acc_raddr = (state_nxt == ST_E_FN) ? col_nxt : row_nxt;
  end

  always_ff @(posedge clk) begin
    if (cb_we) begin
      cb_mem[cb_waddr] <= cb_wdata;
    end
    cb_rd_r <= cb_mem[cb_raddr];
  end

  always_ff @(posedge clk) begin
    if (tp_we) begin
      tp_mem[tp_waddr] <= tp_wdata;
    end
    tp_rd_r <= tp_mem[tp_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      sum_mem[best_r] <= sum_eff + SW'(x_r);
      cnt_mem[best_r] <= cnt_eff + CW'(1);
    end
    sum_rd_r <= sum_mem[acc_raddr];
    cnt_rd_r <= cnt_mem[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int k = 0; k < MAX_LEVELS; k++) begin
        vld_r[k] <= 1'b0;
      end
      avld_rd_r <= 1'b0;
    end else begin
      if (acc_we) begin
        vld_r[best_r] <= 1'b1;
      end
      avld_rd_r <= vld_r[acc_raddr];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    best_nxt   = best_r;
    s_nxt      = s_r;
    bcost_nxt  = bcost_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    dq_nxt     = dq_r;
    dcnt_nxt   = dcnt_r;
    empty_nxt  = empty_r;
    cw_nxt     = cw_r;
    mul_a      = '0;
    mul_b      = '0;
    cb_we      = 1'b0;
    cb_waddr   = LW'(in_row_index);
    cb_wdata   = in_sample;
    tp_we      = 1'b0;
    tp_waddr   = TAW'(32'(LW'(in_row_index)) * MAX_LEVELS + 32'(LW'(in_col_index)));
    tp_wdata   = (in_probability > PROB_ONE) ? PROB_ONE : in_probability;
    acc_we     = 1'b0;
    clr        = 1'b0;
    out_load   = 1'b0;
    oidx_nxt   = oidx_r;
    ocost_nxt  = ocost_r;
    ocw_nxt    = ocw_r;
    oempty_nxt = oempty_r;
    olast_nxt  = olast_r;
    d          = 17'(x_r) - 17'(cb_rd_r);
    ad         = d[16] ? 16'(-d) : 16'(d);
    esum       = s_r + AW'(prod_r[48:0]);
    better     = (row_r == '0) || (esum < bcost_r);
    csh        = bcost_r >> 16;
    rem_sh     = {rem_r, dq_r[NW-1]};
    ge         = (rem_sh >= {1'b0, den_r});
    rnd        = ({rem_r, 1'b0} >= {1'b0, den_r});
    qr         = {1'b0, dq_r} + (NW+1)'(rnd);
    q17        = (qr > (NW+1)'(32768)) ? 17'd32768 : 17'(qr);

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_opcode)
            OP_LOAD_CW: cb_we = row_ok;
            OP_LOAD_P:  tp_we = row_ok && col_ok;
            OP_CLEAR:   clr = 1'b1;
            OP_ENCODE: begin
              x_nxt     = in_sample;
              row_nxt   = '0;
              col_nxt   = '0;
              s_nxt     = '0;
              state_nxt = ST_E_SQ;
            end
            OP_UPDATE: begin
              row_nxt   = '0;
              col_nxt   = '0;
              num_nxt   = '0;
              den_nxt   = '0;
              state_nxt = ST_U_MS;
            end
            default: ;
          endcase
        end
      end
      ST_E_SQ: begin
        mul_a     = MA'(ad);
        mul_b     = 18'(ad);
        state_nxt = ST_E_MP;
      end
      ST_E_MP: begin
        mul_a     = MA'(prod_r[31:0]);
        mul_b     = {1'b0, tp_rd_r};
        state_nxt = ST_E_AC;
      end
      ST_E_AC: begin
        if (col_r == last_idx) begin
          s_nxt = '0;
          if (better) begin
            best_nxt  = row_r;
            bcost_nxt = esum;
          end
          if (row_r == last_idx) begin
            col_nxt   = better ? row_r : best_r;
            state_nxt = ST_E_FN;
          end else begin
            row_nxt   = row_r + LW'(1);
            col_nxt   = '0;
            state_nxt = ST_E_SQ;
          end
        end else begin
          s_nxt     = esum;
          col_nxt   = col_r + LW'(1);
          state_nxt = ST_E_SQ;
        end
      end
      ST_E_FN: begin
        if (out_free) begin
          out_load   = 1'b1;
          oidx_nxt   = 6'(best_r);
          ocost_nxt  = (|(csh >> 40)) ? '1 : 40'(csh);
          ocw_nxt    = cb_rd_r;
          oempty_nxt = 1'b0;
          olast_nxt  = 1'b1;
          acc_we     = (32'(cnt_eff) < MAX_SAMPLES);
          state_nxt  = ST_IDLE;
        end
      end
      ST_U_MS: begin
        mul_a     = MA'(sum_eff);
        mul_b     = {1'b0, tp_rd_r};
        state_nxt = ST_U_MN;
      end
      ST_U_MN: begin
        num_nxt   = num_r + NW'(prod_r);
        mul_a     = MA'(cnt_eff);
        mul_b     = {1'b0, tp_rd_r};
        state_nxt = ST_U_AN;
      end
      ST_U_AN: begin
        den_nxt = den_r + DW'(prod_r);
        if (row_r == last_idx) begin
          state_nxt = ST_U_CK;
        end else begin
          row_nxt   = row_r + LW'(1);
          state_nxt = ST_U_MS;
        end
      end
      ST_U_CK: begin
        empty_nxt = (den_r == '0);
        dq_nxt    = num_r[NW-1] ? NW'(-num_r) : NW'(num_r);
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = (den_r == '0) ? ST_U_EM : ST_U_DV;
      end
      ST_U_DV: begin
        rem_nxt  = ge ? DW'(rem_sh - {1'b0, den_r}) : DW'(rem_sh);
        dq_nxt   = {dq_r[NW-2:0], ge};
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(NW - 1)) begin
          state_nxt = ST_U_RD;
        end
      end
      ST_U_RD: begin
        if (num_r[NW-1]) begin
          cw_nxt = 16'(-q17);
        end else begin
          cw_nxt = (q17 == 17'd32768) ? 16'sh7FFF : 16'(q17);
        end
        state_nxt = ST_U_EM;
      end
      ST_U_EM: begin
        if (out_free) begin
          out_load   = 1'b1;
          oidx_nxt   = 6'(col_r);
          ocost_nxt  = '0;
          ocw_nxt    = empty_r ? cb_rd_r : cw_r;
          oempty_nxt = empty_r;
          olast_nxt  = (col_r == last_idx);
          cb_we      = !empty_r;
          cb_waddr   = col_r;
          cb_wdata   = cw_r;
          if (col_r == last_idx) begin
            state_nxt = ST_IDLE;
          end else begin
            col_nxt   = col_r + LW'(1);
            row_nxt   = '0;
            num_nxt   = '0;
            den_nxt   = '0;
            state_nxt = ST_U_MS;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

endmodule

// ----- rtl/cosq_checker.sv -----
// Port-level checker for the quantiser top level, attached by bind.
// Depends on cosq_pkg for the opcode codes.
module cosq_checker
  import cosq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  in_opcode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_cell_index,
  input logic [39:0] out_cost,
  input logic [15:0] out_codeword,
  input logic        out_empty_cell,
  input logic        out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cell_index) && $stable(out_codeword)
      && $stable(out_cost) && $stable(out_last))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == OP_ENCODE || in_opcode == OP_UPDATE) |=> in_stall)
    else $error("not busy after encode or update transfer");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_cell |-> out_cost == 40'd0)
    else $error("empty cell with non-zero cost");

  a_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("ready while an update is still emitting");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cosq_encode_and_centroid_update cosq_checker u_cosq_checker (.*);

// ----- test/tb_top.sv -----
// Testbench for cosq_encode_and_centroid_update: loads, clear, encode and centroid update.
// A scoreboard class predicts every result from its own copy of the stores; depends on
// cosq_pkg and the block only.
`timescale 1ns / 1ps

module tb_top;
  import cosq_pkg::*;

  localparam int NLEV = 64;
  localparam int NSAMP_MAX = 1048576;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [5:0]         idx;
    logic [39:0]        cost;
    logic signed [15:0] cw;
    logic               empty;
    logic               last;
  } cell_result_t;

  class cosq_scoreboard;
    logic signed [15:0] codebook[NLEV];
    logic [16:0]        trans[NLEV*NLEV];
    longint             cell_sum[NLEV];
    int unsigned        cell_cnt[NLEV];
    int unsigned        lg_levels;
    cell_result_t       awaited_q[$];
    int                 errors;
    int                 n_checked;
    int                 n_encodes;
    int                 n_updates;

    function new();
      lg_levels = 4;
      errors = 0;
      n_checked = 0;
      n_encodes = 0;
      n_updates = 0;
      foreach (cell_sum[i]) begin
        cell_sum[i] = 0;
        cell_cnt[i] = 0;
        codebook[i] = '0;
      end
      foreach (trans[i]) trans[i] = '0;
    endfunction

    function int unsigned levels();
      int unsigned l;
      l = 1 << lg_levels;
      return (l > NLEV) ? NLEV : l;
    endfunction

    function void note_input(logic [2:0] op, logic [5:0] row, logic [5:0] col,
                             logic signed [15:0] x, logic [16:0] p);
      int unsigned l_use, best;
      longint unsigned s, best_s, dd, den, mag, q, r, cst;
      longint d, num, v;
      bit neg, empty;
      cell_result_t res;
      l_use = levels();
      case (op)
        OP_LOAD_CW: codebook[row] = x;
        OP_LOAD_P:  trans[row*NLEV + col] = (p > PROB_ONE) ? PROB_ONE : p;
        OP_CLEAR: begin
          foreach (cell_sum[i]) begin
            cell_sum[i] = 0;
            cell_cnt[i] = 0;
          end
        end
        OP_ENCODE: begin
          best = 0;
          best_s = 0;
          for (int unsigned l = 0; l < l_use; l++) begin
            s = 0;
            for (int unsigned j = 0; j < l_use; j++) begin
              d = longint'(x) - longint'(codebook[j]);
              dd = d * d;
              s += dd * longint'(trans[l*NLEV + j]);
            end
            if (l == 0 || s < best_s) begin
              best = l;
              best_s = s;
            end
          end
          if (cell_cnt[best] < NSAMP_MAX) begin
            cell_cnt[best]++;
            cell_sum[best] += longint'(x);
          end
          cst = best_s >> 16;
          if (cst > 64'hFF_FFFF_FFFF) cst = 64'hFF_FFFF_FFFF;
          res.idx = best[5:0];
          res.cost = cst[39:0];
          res.cw = codebook[best];
          res.empty = 1'b0;
          res.last = 1'b1;
          awaited_q.push_back(res);
          n_encodes++;
        end
        OP_UPDATE: begin
          for (int unsigned j = 0; j < l_use; j++) begin
            num = 0;
            den = 0;
            for (int unsigned i = 0; i < l_use; i++) begin
              num += longint'(trans[i*NLEV + j]) * cell_sum[i];
              den += longint'(trans[i*NLEV + j]) * longint'(cell_cnt[i]);
            end
            empty = (den == 0);
            if (!empty) begin
              neg = num < 0;
              mag = neg ? -num : num;
              q = mag / den;
              r = mag % den;
              if (r >= den - r) q++;
              if (q > 32768) q = 32768;
              v = neg ? -longint'(q) : longint'(q);
              if (v > 32767) v = 32767;
              codebook[j] = v[15:0];
            end
            res.idx = j[5:0];
            res.cost = '0;
            res.cw = codebook[j];
            res.empty = empty;
            res.last = (j + 1 == l_use);
            awaited_q.push_back(res);
          end
          n_updates++;
        end
        default: ;
      endcase
    endfunction

    function void check_result(cell_result_t act);
      cell_result_t exp_r;
      if (awaited_q.size() == 0) begin
        $display("%0t: unexpected result cell=%0d cost=%0h codeword=%0d", $time,
                 act.idx, act.cost, act.cw);
        errors++;
        return;
      end
      exp_r = awaited_q.pop_front();
      n_checked++;
      if (act.idx !== exp_r.idx) begin
        $display("%0t: cell_index expected %0d actual %0d", $time, exp_r.idx, act.idx);
        errors++;
      end
      if (act.cost !== exp_r.cost) begin
        $display("%0t: cost expected %0h actual %0h", $time, exp_r.cost, act.cost);
        errors++;
      end
      if (act.cw !== exp_r.cw) begin
        $display("%0t: codeword expected %0d actual %0d", $time, exp_r.cw, act.cw);
        errors++;
      end
      if (act.empty !== exp_r.empty) begin
        $display("%0t: empty_cell expected %0b actual %0b", $time, exp_r.empty, act.empty);
        errors++;
      end
      if (act.last !== exp_r.last) begin
        $display("%0t: last expected %0b actual %0b", $time, exp_r.last, act.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_opcode;
  logic [5:0]         in_row_index;
  logic [5:0]         in_col_index;
  logic signed [15:0] in_sample;
  logic [16:0]        in_probability;
  logic               out_valid;
  logic               out_stall;
  logic [5:0]         out_cell_index;
  logic [39:0]        out_cost;
  logic signed [15:0] out_codeword;
  logic               out_empty_cell;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_data;

  cosq_scoreboard sb;
  bit  cw_written[NLEV];
  bit  p_written[NLEV*NLEV];
  bit  calm_sender;
  bit  calm_receiver;
  bit  hold_done;
  int  idle_cycles;

  cosq_encode_and_centroid_update u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_sample      (in_sample),
    .in_probability (in_probability),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_index (out_cell_index),
    .out_cost       (out_cost),
    .out_codeword   (out_codeword),
    .out_empty_cell (out_empty_cell),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'(signed'($urandom_range(0, 8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] pick_prob();
    case ($urandom_range(0, 7))
      0: return PROB_ONE;
      1: return 17'd0;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic send_item(logic [2:0] op, logic [5:0] row, logic [5:0] col,
                           logic signed [15:0] x, logic [16:0] p);
    int gap;
    gap = calm_sender ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_row_index   <= row;
    in_col_index   <= col;
    in_sample      <= x;
    in_probability <= p;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, row, col, x, p);
    if (op == OP_LOAD_CW) cw_written[row] = 1'b1;
    if (op == OP_LOAD_P) p_written[row*NLEV + col] = 1'b1;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_levels(logic [2:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.lg_levels = v;
  endtask

  // fill every codebook and transition entry that L levels will read
  task automatic fill_stores();
    int unsigned l_use;
    l_use = sb.levels();
    for (int unsigned i = 0; i < l_use; i++)
      if (!cw_written[i]) send_item(OP_LOAD_CW, i[5:0], 6'($urandom), pick_sample(), 17'($urandom));
    for (int unsigned i = 0; i < l_use; i++)
      for (int unsigned j = 0; j < l_use; j++)
        if (!p_written[i*NLEV + j])
          send_item(OP_LOAD_P, i[5:0], j[5:0], 16'($urandom), pick_prob());
  endtask

  task automatic random_items(int n);
    int w;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) calm_sender = ($urandom_range(0, 3) == 0);
      w = $urandom_range(0, 99);
      if (w < 22)
        send_item(OP_LOAD_CW, 6'($urandom), 6'($urandom), pick_sample(), 17'($urandom));
      else if (w < 44)
        send_item(OP_LOAD_P, 6'($urandom), 6'($urandom), 16'($urandom), pick_prob());
      else if (w < 48)
        send_item(OP_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom), 17'($urandom));
      else if (w < 88)
        send_item(OP_ENCODE, 6'($urandom), 6'($urandom), pick_sample(), 17'($urandom));
      else if (w < 95)
        send_item(OP_UPDATE, 6'($urandom), 6'($urandom), 16'($urandom), 17'($urandom));
      else
        send_item(3'($urandom_range(5, 7)), 6'($urandom), 6'($urandom), 16'($urandom),
                  17'($urandom));
    end
    calm_sender = 1'b0;
  endtask

  task automatic run_phase(logic [2:0] lg, int n);
    write_levels(lg);
    fill_stores();
    random_items(n);
  endtask

  // receiver: random stall before each transfer, one long hold-off
  initial begin
    int n;
    out_stall <= 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && sb.n_checked >= 25) begin
        hold_done = 1'b1;
        n = 2400;
      end else begin
        n = calm_receiver ? 0 : $urandom_range(0, 16);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result('{out_cell_index, out_cost, out_codeword, out_empty_cell, out_last});
      if ($urandom_range(0, 30) == 0) calm_receiver = ~calm_receiver;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    sb = new();
    calm_sender = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= OP_CLEAR;
    in_row_index <= '0;
    in_col_index <= '0;
    in_sample <= '0;
    in_probability <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset level count of sixteen, extremes and every opcode
    fill_stores();
    send_item(OP_UPDATE, 6'd0, 6'd0, 16'sd0, 17'd0);
    send_item(OP_LOAD_CW, 6'd0, 6'd0, 16'sh8000, 17'd0);
    send_item(OP_LOAD_CW, 6'd15, 6'd0, 16'sh7FFF, 17'd0);
    send_item(OP_LOAD_CW, 6'd63, 6'd63, 16'sh7FFF, 17'h1FFFF);
    send_item(OP_LOAD_P, 6'd0, 6'd0, 16'sd0, 17'h1FFFF);
    send_item(OP_LOAD_P, 6'd0, 6'd15, 16'sd0, PROB_ONE);
    send_item(OP_LOAD_P, 6'd15, 6'd0, 16'sd0, 17'd0);
    send_item(OP_LOAD_P, 6'd63, 6'd63, 16'sd0, 17'd65537);
    send_item(OP_ENCODE, 6'd0, 6'd0, 16'sh8000, 17'd0);
    send_item(OP_ENCODE, 6'd63, 6'd63, 16'sh7FFF, 17'h1FFFF);
    send_item(OP_ENCODE, 6'd0, 6'd0, 16'sd0, 17'd0);
    send_item(OP_ENCODE, 6'd0, 6'd0, 16'sh7FFF, 17'd0);
    send_item(3'd5, 6'd1, 6'd1, 16'sd1, 17'd1);
    send_item(3'd6, 6'd63, 6'd63, 16'sh8000, 17'h1FFFF);
    send_item(3'd7, 6'd0, 6'd0, 16'sd0, 17'd0);
    send_item(OP_UPDATE, 6'd0, 6'd0, 16'sd0, 17'd0);
    send_item(OP_CLEAR, 6'd0, 6'd0, 16'sd0, 17'd0);
    send_item(OP_UPDATE, 6'd0, 6'd0, 16'sd0, 17'd0);

    random_items(20);
    settle();
    random_items(15);
    run_phase(3'd0, 8);
    run_phase(3'd1, 8);
    run_phase(3'd2, 8);
    run_phase(3'd3, 8);
    run_phase(3'd4, 13);
    settle();
    repeat (50) @(posedge clk);

    $display("Run covered %0d encodes and %0d centroid updates, %0d results checked,",
             sb.n_encodes, sb.n_updates, sb.n_checked);
    $display("over level counts from 1 to 16 with random gaps and stalls on both sides.");
    if (sb.errors == 0 && sb.awaited_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cosq_pkg.sv
rtl/cosq_encode_and_centroid_update.sv
rtl/cosq_checker.sv
test/tb_top.sv
